// ===== rtl/mrpt_pkg.sv =====
//------------------------------------------------------------------------------
// mrpt_pkg
// Types, constants and command codes of the multipath route path table.
//------------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;

	localparam int PATH_SLOTS = 8;
	localparam int IDX_W = (PATH_SLOTS > 1) ? $clog2(PATH_SLOTS) : 1;
	localparam int CNT_W = 7;
	localparam int ENTRY_W = 32 + 32 + 16 + 32;
	localparam logic [15:0] HOP_CEILING = 16'hffff;

	typedef enum logic [3:0] {
		CMD_INSERT    = 4'd0,
		CMD_FIND_NEXT = 4'd1,
		CMD_FIND_BOTH = 4'd2,
		CMD_FIND_LAST = 4'd3,
		CMD_DISJOINT  = 4'd4,
		CMD_DEL_NEXT  = 4'd5,
		CMD_CLEAR     = 4'd6,
		CMD_DEL_LONG  = 4'd7,
		CMD_MIN_PATH  = 4'd8,
		CMD_FIRST     = 4'd9,
		CMD_MAX_HOPS  = 4'd10,
		CMD_MIN_HOPS  = 4'd11,
		CMD_MAX_EXP   = 4'd12,
		CMD_PURGE     = 4'd13
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [31:0] next_hop;
		logic [31:0] last_hop;
		logic [15:0] hops;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [31:0] next_hop;
		logic [31:0] last_hop;
		logic [15:0] hop_count;
		logic [31:0] expire_at;
		logic [31:0] now_tick;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] hit_next_hop;
		logic [31:0] hit_last_hop;
		logic [15:0] hit_hop_count;
		logic [31:0] hit_expire;
		logic [15:0] hops_answer;
		logic        is_disjoint;
		logic [6:0]  path_count;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/mrpt_if.sv =====
//------------------------------------------------------------------------------
// mrpt_req_if / mrpt_rsp_if / mrpt_cfg_if
// Valid/ready channels of the path table.
//------------------------------------------------------------------------------
`default_nettype none
interface mrpt_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  cmd;
	logic [31:0] next_hop;
	logic [31:0] last_hop;
	logic [15:0] hop_count;
	logic [31:0] expire_at;
	logic [31:0] now_tick;
	modport source (output valid, cmd, next_hop, last_hop, hop_count, expire_at, now_tick,
		input ready);
	modport sink (input valid, cmd, next_hop, last_hop, hop_count, expire_at, now_tick,
		output ready);
endinterface

interface mrpt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] hit_next_hop;
	logic [31:0] hit_last_hop;
	logic [15:0] hit_hop_count;
	logic [31:0] hit_expire;
	logic [15:0] hops_answer;
	logic        is_disjoint;
	logic [6:0]  path_count;
	modport source (output valid, status, hit_next_hop, hit_last_hop, hit_hop_count,
		hit_expire, hops_answer, is_disjoint, path_count, input ready);
	modport sink (input valid, status, hit_next_hop, hit_last_hop, hit_hop_count,
		hit_expire, hops_answer, is_disjoint, path_count, output ready);
endinterface

interface mrpt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/multipath_route_path_table.sv =====
//------------------------------------------------------------------------------
// multipath_route_path_table
// Insertion-ordered table of alternative paths toward one destination.
//------------------------------------------------------------------------------
// Each command word is handled alone. The entries live in one RAM with a
// registered read, so a command scans the held entries one per cycle, and
// first-path scans the same way. A delete then copies each entry above the
// removed one down through the same read port. Purge compacts while it
// scans. Insert, clear and the unused codes go straight to the output
// register without a scan. A configuration write waits while a command
// word is offered. The result waits in an output register.
`default_nettype none
module multipath_route_path_table (
	input  wire logic clk,
	input  wire logic arst_n,
	mrpt_cfg_if.sink  cfg,
	mrpt_req_if.sink  req,
	mrpt_rsp_if.source rsp
);
	import mrpt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_WAIT = 6'b000100,
		S_MOVE = 6'b001000,
		S_DONE = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	req_t   req_q;
	rsp_t   rsp_q;
	logic [15:0] inf_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] rd_q;     // index of the entry read last cycle
	logic [CNT_W-1:0] wr_q;     // compaction write pointer
	logic rd_vld_q;
	logic found_q;
	logic [15:0] acc_q;
	logic [31:0] accx_q;
	logic purge_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	entry_t ent;
	logic [CNT_W-1:0] raddr_full;

	assign ent = entry_t'(rdata);

	mrpt_ram #(.WIDTH(ENTRY_W), .DEPTH(PATH_SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign cfg.ready = (state_q == S_IDLE) && !req.valid;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.status = rsp_q.status;
	assign rsp.hit_next_hop = rsp_q.hit_next_hop;
	assign rsp.hit_last_hop = rsp_q.hit_last_hop;
	assign rsp.hit_hop_count = rsp_q.hit_hop_count;
	assign rsp.hit_expire = rsp_q.hit_expire;
	assign rsp.hops_answer = rsp_q.hops_answer;
	assign rsp.is_disjoint = rsp_q.is_disjoint;
	assign rsp.path_count = rsp_q.path_count;

	// Entry hit test for the scanning commands.
	logic hit;
	always_comb begin
		case (req_q.cmd)
			CMD_FIND_BOTH: hit = ent.next_hop == req_q.next_hop &&
				ent.last_hop == req_q.last_hop;
			CMD_FIND_LAST: hit = ent.last_hop == req_q.last_hop;
			CMD_DISJOINT:  hit = ent.next_hop == req_q.next_hop ||
				ent.last_hop == req_q.last_hop;
			CMD_PURGE:     hit = ent.expiry < req_q.now_tick;
			default:       hit = ent.next_hop == req_q.next_hop;
		endcase
	end

	always_comb begin
		raddr_full = rd_q + 1'b1;
		if (state_q == S_IDLE) begin
			raddr_full = '0;
		end
		raddr = raddr_full[IDX_W-1:0];
		we = 1'b0;
		waddr = wr_q[IDX_W-1:0];
		wdata = rdata;
		if (state_q == S_IDLE) begin
			waddr = occ_q[IDX_W-1:0];
			wdata = {req.next_hop, req.last_hop, req.hop_count, req.expire_at};
			we = req.valid && req.cmd == CMD_INSERT && occ_q < CNT_W'(PATH_SLOTS);
		end else if (state_q == S_MOVE && rd_vld_q) begin
			// During compaction, an entry read last cycle is kept unless purged.
			we = !(purge_q && hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inf_q <= 16'd255;
			occ_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			rd_vld_q <= 1'b0;
			found_q <= 1'b0;
			purge_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg.valid && !req.valid) begin
						inf_q <= cfg.data;
					end
					rd_q <= '0;
					rd_vld_q <= 1'b0;
					found_q <= 1'b0;
					purge_q <= 1'b0;
					if (req.valid) begin
						req_q <= '{req.cmd, req.next_hop, req.last_hop, req.hop_count,
							req.expire_at, req.now_tick};
						rsp_q <= '0;
						acc_q <= (req.cmd == CMD_MIN_PATH) ? HOP_CEILING :
							(req.cmd == CMD_MIN_HOPS) ? inf_q : 16'd0;
						accx_q <= '0;
						case (req.cmd)
							CMD_INSERT: begin
								if (occ_q >= CNT_W'(PATH_SLOTS)) begin
									rsp_q.status <= ST_FULL;
									rsp_q.path_count <= occ_q;
								end else begin
									rsp_q.hit_next_hop <= req.next_hop;
									rsp_q.hit_last_hop <= req.last_hop;
									rsp_q.hit_hop_count <= req.hop_count;
									rsp_q.hit_expire <= req.expire_at;
									rsp_q.path_count <= occ_q + 1'b1;
									occ_q <= occ_q + 1'b1;
								end
								state_q <= S_OUT;
							end
							CMD_CLEAR: begin
								occ_q <= '0;
								state_q <= S_OUT;
							end
							CMD_PURGE: begin
								purge_q <= 1'b1;
								wr_q <= '0;
								rd_vld_q <= (occ_q != '0);
								state_q <= S_MOVE;
							end
							default: begin
								if (req.cmd > CMD_PURGE) begin
									rsp_q.status <= ST_MISS;
									rsp_q.path_count <= occ_q;
									state_q <= S_OUT;
								end else begin
									rd_vld_q <= (occ_q != '0);
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					// rdata holds entry rd_q when rd_vld_q is set.
					if (rd_vld_q) begin
						case (req_q.cmd)
							CMD_FIND_NEXT, CMD_FIND_BOTH, CMD_FIND_LAST, CMD_DEL_NEXT,
							CMD_FIRST: begin
								if ((hit || req_q.cmd == CMD_FIRST) && !found_q) begin
									found_q <= 1'b1;
									wr_q <= rd_q;
									rsp_q.hit_next_hop <= ent.next_hop;
									rsp_q.hit_last_hop <= ent.last_hop;
									rsp_q.hit_hop_count <= ent.hops;
									rsp_q.hit_expire <= ent.expiry;
								end
							end
							CMD_DISJOINT: begin
								if (hit) begin
									found_q <= 1'b1;
								end
							end
							CMD_DEL_LONG, CMD_MAX_HOPS: begin
								if (ent.hops > acc_q) begin
									acc_q <= ent.hops;
									found_q <= 1'b1;
									wr_q <= rd_q;
									rsp_q.hit_next_hop <= ent.next_hop;
									rsp_q.hit_last_hop <= ent.last_hop;
									rsp_q.hit_hop_count <= ent.hops;
									rsp_q.hit_expire <= ent.expiry;
								end
							end
							CMD_MIN_PATH, CMD_MIN_HOPS: begin
								if (ent.hops < acc_q) begin
									acc_q <= ent.hops;
									found_q <= 1'b1;
									rsp_q.hit_next_hop <= ent.next_hop;
									rsp_q.hit_last_hop <= ent.last_hop;
									rsp_q.hit_hop_count <= ent.hops;
									rsp_q.hit_expire <= ent.expiry;
								end
							end
							CMD_MAX_EXP: begin
								if (ent.expiry > accx_q) begin
									accx_q <= ent.expiry;
								end
							end
							default: begin
							end
						endcase
					end
					if (rd_vld_q && rd_q + 1'b1 < occ_q) begin
						rd_q <= rd_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rsp_q.path_count <= occ_q;
					state_q <= S_OUT;
					case (req_q.cmd)
						CMD_FIND_NEXT, CMD_FIND_BOTH, CMD_FIND_LAST, CMD_FIRST,
						CMD_MIN_PATH: begin
							if (!found_q) begin
								rsp_q.status <= ST_MISS;
							end
						end
						CMD_DISJOINT: begin
							rsp_q.is_disjoint <= !found_q;
						end
						CMD_DEL_NEXT, CMD_DEL_LONG: begin
							if (!found_q) begin
								rsp_q.status <= ST_MISS;
							end else begin
								// Copy entries above the removed one down by one.
								rd_q <= wr_q;
								rd_vld_q <= 1'b0;
								state_q <= S_WAIT;
							end
						end
						CMD_MAX_HOPS: begin
							rsp_q <= '0;
							rsp_q.path_count <= occ_q;
							rsp_q.hops_answer <= (acc_q == 16'd0) ? inf_q : acc_q;
						end
						CMD_MIN_HOPS: begin
							rsp_q <= '0;
							rsp_q.path_count <= occ_q;
							rsp_q.hops_answer <= acc_q;
						end
						CMD_MAX_EXP: begin
							rsp_q.hit_expire <= accx_q;
						end
						default: begin
						end
					endcase
				end
				S_WAIT: begin
					// Reading entry rd_q + 1 this cycle; the removed slot is skipped.
					if (rd_q + 1'b1 < occ_q) begin
						rd_vld_q <= 1'b1;
						rd_q <= rd_q + 1'b1;
						state_q <= S_MOVE;
					end else begin
						occ_q <= occ_q - 1'b1;
						rsp_q.path_count <= occ_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_MOVE: begin
					if (rd_vld_q && !(purge_q && hit)) begin
						wr_q <= wr_q + 1'b1;
					end
					if (rd_vld_q && rd_q + 1'b1 < occ_q) begin
						rd_q <= rd_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (purge_q) begin
							occ_q <= wr_q + CNT_W'(rd_vld_q && !hit);
							rsp_q.path_count <= wr_q + CNT_W'(rd_vld_q && !hit);
						end else begin
							occ_q <= occ_q - 1'b1;
							rsp_q.path_count <= occ_q - 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/mrpt_ram.sv =====
//------------------------------------------------------------------------------
// mrpt_ram
// Generic single-port write, single-port read RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module mrpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
